>>> hw/rtl/edmc_pkg.sv
// ----------------------------------------------------------------------------
// Encoder distance motion control package
// Transaction types, command codes and motion constants shared by the core.
// ----------------------------------------------------------------------------
package edmc_pkg;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_START  = 2'd1;
  localparam logic [1:0] MODE_DRIVE  = 2'd2;

  localparam logic [1:0] KIND_GO     = 2'd0;
  localparam logic [1:0] KIND_BACK   = 2'd1;
  localparam logic [1:0] KIND_LEFT   = 2'd2;
  localparam logic [1:0] KIND_RIGHT  = 2'd3;

  localparam logic CFG_SAMPLING_ENABLE = 1'b0;
  localparam logic CFG_SAMPLE_PERIOD   = 1'b1;

  localparam logic [7:0] DEFAULT_PERIOD = 8'd20;

  localparam int DRIVE_LIMIT = 1000;
  localparam int GO_DUTY     = 150;
  localparam int TURN_DUTY   = 100;
  localparam int BACK_GOAL   = 240;
  localparam int SIDE_GOAL   = 120;
  localparam int SCALE_NUM   = 100;
  localparam int SCALE_DEN   = 13 * 2 * 30;

  // Turn goals scaled by SCALE_DEN / SCALE_NUM divide exactly.
  localparam logic signed [31:0] BACK_TRAVEL = 32'(BACK_GOAL * SCALE_DEN / SCALE_NUM);
  localparam logic signed [31:0] SIDE_TRAVEL = 32'(SIDE_GOAL * SCALE_DEN / SCALE_NUM);

  typedef struct packed {
    logic [1:0]         mode;
    logic [1:0]         motion_kind;
    logic signed [15:0] goal_distance;
    logic signed [7:0]  left_step;
    logic signed [7:0]  right_step;
    logic signed [15:0] drive_a;
    logic signed [15:0] drive_b;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         duty_a;
    logic               forward_a;
    logic [9:0]         duty_b;
    logic               forward_b;
    logic               moving;
    logic               motion_done;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic signed [31:0] left_travel;
    logic signed [31:0] right_travel;
  } out_item_t;

endpackage

>>> hw/rtl/encoder_distance_motion_control_core.sv
// ----------------------------------------------------------------------------
// Encoder distance motion control core
// Drives two DC motors, samples encoder speeds and ends distance-limited
// motions when the scaled travel reaches its goal.
//
//   Channel | Ports                              | Payload
//   --------+------------------------------------+-------------
//   input   | in_valid, in_stall, in_item        | in_item_t
//   result  | out_valid, out_stall, out_item     | out_item_t
//   config  | cfg_we, cfg_index, cfg_wdata       | 8-bit data
//
// Each transaction is registered, processed and placed in the result register,
// so the core takes one transaction per cycle while the result side does not
// stall. Reset is synchronous and clears the valid flags, configuration and
// motion state with no clearing pass; the item registers are not reset.
// A stall on the result side holds the result register and backs up into
// the input register; new transactions are refused only when both are full.
// ----------------------------------------------------------------------------
module encoder_distance_motion_control_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  edmc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output edmc_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata
);
  import edmc_pkg::*;

  logic               s1_valid_r;
  in_item_t           s1_item_r;
  logic               out_valid_r;
  out_item_t          out_item_r;
  out_item_t          out_item_nxt;

  logic               sampling_enable_r;
  logic [7:0]         sample_period_r;

  logic [7:0]         tick_divider_r, tick_divider_nxt;
  logic [15:0]        left_window_r, left_window_nxt;
  logic [15:0]        right_window_r, right_window_nxt;
  logic [15:0]        left_speed_r, left_speed_nxt;
  logic [15:0]        right_speed_r, right_speed_nxt;
  logic signed [31:0] left_travel_r, left_travel_nxt;
  logic signed [31:0] right_travel_r, right_travel_nxt;
  logic               busy_r, busy_nxt;
  logic [1:0]         active_kind_r, active_kind_nxt;
  logic signed [21:0] goal_scaled_r, goal_scaled_nxt;
  logic signed [10:0] drive_a_r, drive_a_nxt;
  logic signed [10:0] drive_b_r, drive_b_nxt;

  logic               s1_adv;
  logic               out_free;
  logic               in_acc;

  logic [15:0]        lw_sum, rw_sum;
  logic [7:0]         div_inc;
  logic               latch;
  logic signed [31:0] l_new, r_new;
  logic signed [34:0] l5, r5;
  logic signed [21:0] g22;
  logic               finished;
  logic               done;

  function automatic logic signed [10:0] clamp_drive(input logic signed [15:0] v);
    logic signed [10:0] res;
    if (v > 16'sd1000) begin
      res = 11'(DRIVE_LIMIT);
    end else if (v < -16'sd1000) begin
      res = -11'sd1000;
    end else begin
      res = v[10:0];
    end
    return res;
  endfunction

  function automatic logic [9:0] drive_mag(input logic signed [10:0] d);
    logic signed [10:0] m;
    m = (d < 11'sd0) ? -d : d;
    return m[9:0];
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    lw_sum   = left_window_r + 16'(s1_item_r.left_step);
    rw_sum   = right_window_r + 16'(s1_item_r.right_step);
    div_inc  = tick_divider_r + 8'd1;
    latch    = sampling_enable_r && (div_inc >= sample_period_r);
    l_new    = left_travel_r;
    r_new    = right_travel_r;
    if (latch && busy_r) begin
      l_new = left_travel_r + 32'(signed'(-lw_sum));
      r_new = right_travel_r + 32'(signed'(rw_sum));
    end
    l5 = (35'(l_new) <<< 2) + 35'(l_new);
    r5 = (35'(r_new) <<< 2) + 35'(r_new);

    case (active_kind_r)
      KIND_GO: begin
        finished = (l5 >= 35'(goal_scaled_r)) || (r5 >= 35'(goal_scaled_r));
      end
      KIND_BACK: begin
        finished = (l_new <= -BACK_TRAVEL) || (r_new >= BACK_TRAVEL);
      end
      KIND_LEFT: begin
        finished = (l_new <= -SIDE_TRAVEL) || (r_new >= SIDE_TRAVEL);
      end
      default: begin
        finished = (l_new >= SIDE_TRAVEL) || (r_new <= -SIDE_TRAVEL);
      end
    endcase

    g22 = 22'(s1_item_r.goal_distance);

    tick_divider_nxt = tick_divider_r;
    left_window_nxt  = left_window_r;
    right_window_nxt = right_window_r;
    left_speed_nxt   = left_speed_r;
    right_speed_nxt  = right_speed_r;
    left_travel_nxt  = left_travel_r;
    right_travel_nxt = right_travel_r;
    busy_nxt         = busy_r;
    active_kind_nxt  = active_kind_r;
    goal_scaled_nxt  = goal_scaled_r;
    drive_a_nxt      = drive_a_r;
    drive_b_nxt      = drive_b_r;
    done             = 1'b0;

    case (s1_item_r.mode)
      MODE_TICK: begin
        left_window_nxt  = lw_sum;
        right_window_nxt = rw_sum;
        if (sampling_enable_r) begin
          tick_divider_nxt = div_inc;
        end
        if (latch) begin
          tick_divider_nxt = 8'd0;
          left_speed_nxt   = -lw_sum;
          right_speed_nxt  = rw_sum;
          left_window_nxt  = 16'd0;
          right_window_nxt = 16'd0;
          left_travel_nxt  = l_new;
          right_travel_nxt = r_new;
        end
        if (busy_r && finished) begin
          drive_a_nxt = 11'sd0;
          drive_b_nxt = 11'sd0;
          busy_nxt    = 1'b0;
          done        = 1'b1;
        end
      end
      MODE_START: begin
        active_kind_nxt  = s1_item_r.motion_kind;
        goal_scaled_nxt  = (g22 <<< 5) + (g22 <<< 2) + (g22 <<< 1) + g22;
        left_travel_nxt  = 32'sd0;
        right_travel_nxt = 32'sd0;
        busy_nxt         = 1'b1;
        case (s1_item_r.motion_kind)
          KIND_GO: begin
            drive_a_nxt = 11'(GO_DUTY);
            drive_b_nxt = 11'(GO_DUTY);
          end
          KIND_BACK, KIND_LEFT: begin
            drive_a_nxt = -11'(TURN_DUTY);
            drive_b_nxt = 11'(TURN_DUTY);
          end
          default: begin
            drive_a_nxt = 11'(TURN_DUTY);
            drive_b_nxt = -11'(TURN_DUTY);
          end
        endcase
        if (s1_item_r.motion_kind == KIND_GO && s1_item_r.goal_distance <= 16'sd0) begin
          drive_a_nxt = 11'sd0;
          drive_b_nxt = 11'sd0;
          busy_nxt    = 1'b0;
          done        = 1'b1;
        end
      end
      MODE_DRIVE: begin
        drive_a_nxt = clamp_drive(s1_item_r.drive_a);
        drive_b_nxt = clamp_drive(s1_item_r.drive_b);
        busy_nxt    = 1'b0;
      end
      default: begin
      end
    endcase

    out_item_nxt.duty_a       = drive_mag(drive_a_nxt);
    out_item_nxt.forward_a    = drive_a_nxt > 11'sd0;
    out_item_nxt.duty_b       = drive_mag(drive_b_nxt);
    out_item_nxt.forward_b    = drive_b_nxt > 11'sd0;
    out_item_nxt.moving       = busy_nxt;
    out_item_nxt.motion_done  = done;
    out_item_nxt.left_speed   = left_speed_nxt;
    out_item_nxt.right_speed  = right_speed_nxt;
    out_item_nxt.left_travel  = left_travel_nxt;
    out_item_nxt.right_travel = right_travel_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      sampling_enable_r <= 1'b0;
      sample_period_r   <= DEFAULT_PERIOD;
      tick_divider_r    <= 8'd0;
      left_window_r     <= 16'd0;
      right_window_r    <= 16'd0;
      left_speed_r      <= 16'd0;
      right_speed_r     <= 16'd0;
      left_travel_r     <= 32'sd0;
      right_travel_r    <= 32'sd0;
      busy_r            <= 1'b0;
      active_kind_r     <= KIND_GO;
      goal_scaled_r     <= 22'sd0;
      drive_a_r         <= 11'sd0;
      drive_b_r         <= 11'sd0;
    end else begin
      s1_valid_r  <= in_acc || (s1_valid_r && !s1_adv);
      out_valid_r <= s1_adv || (out_valid_r && out_stall);
      if (cfg_we) begin
        if (cfg_index == CFG_SAMPLING_ENABLE) begin
          sampling_enable_r <= cfg_wdata[0];
        end else begin
          sample_period_r <= cfg_wdata;
        end
      end
      if (s1_adv) begin
        tick_divider_r <= tick_divider_nxt;
        left_window_r  <= left_window_nxt;
        right_window_r <= right_window_nxt;
        left_speed_r   <= left_speed_nxt;
        right_speed_r  <= right_speed_nxt;
        left_travel_r  <= left_travel_nxt;
        right_travel_r <= right_travel_nxt;
        busy_r         <= busy_nxt;
        active_kind_r  <= active_kind_nxt;
        goal_scaled_r  <= goal_scaled_nxt;
        drive_a_r      <= drive_a_nxt;
        drive_b_r      <= drive_b_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule
